// ===== design/yenc_article_decoder_top_macros.svh =====
// Assertion macros for the yEnc article decoder.
// Needs clk and arst_n in the scope that uses them.
`ifndef YENC_ARTICLE_DECODER_TOP_MACROS_SVH
`define YENC_ARTICLE_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define YAD_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define YAD_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/yad_pkg.sv =====
// Shared types, character codes and the CRC-32 byte update of the yEnc decoder.
// No dependencies.
package yad_pkg;

	localparam int MaxRes = 5;

	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_DOT = 8'h2E;
	localparam logic [7:0] CH_EQ  = 8'h3D;
	localparam logic [7:0] CH_Y   = 8'h79;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic [7:0] DATA_OFS = 8'd42;
	localparam logic [7:0] ESC_OFS  = 8'd106;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

	typedef enum logic [2:0] {
		MODE_LSTART = 3'd0,
		MODE_DOT    = 3'd1,
		MODE_DOTCR  = 3'd2,
		MODE_PREFIX = 3'd3,
		MODE_BODY   = 3'd4,
		MODE_ESC    = 3'd5,
		MODE_SKIP   = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_END  = 2'd1,
		KIND_ERR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
	} entry_t;

	// Characters of the "=yend " tag by position.
	function automatic logic [7:0] yend_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0: c = CH_EQ;
			3'd1: c = CH_Y;
			3'd2: c = 8'h65;
			3'd3: c = 8'h6E;
			3'd4: c = 8'h64;
			3'd5: c = 8'h20;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Reflected CRC-32, one byte folded in.
	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

// ===== design/yenc_article_decoder_top.sv =====
// yEnc article body decoder: byte stream in, data/end/error beats out.
// The first result of a byte is registered and shows on the output in the cycle after the byte is taken.
// Throughput: one input byte per cycle while each byte gives at most one result and the output
// is not stalled; a byte that gives more results holds the input until its last beat is taken.
// The CRC-32 is folded in at the output stage, one byte per delivered data beat.
// Reset: line-start mode, CRC preset to all ones, result buffer empty.
`include "yenc_article_decoder_top_macros.svh"

module yenc_article_decoder_top
	import yad_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] data_byte, [39:8] crc_value
	output logic [1:0]  m_tuser,   // [1:0] kind
	output logic        m_tlast    // last
);

	// Decoder state, advanced once per accepted byte.
	mode_t       mode_q, mode_d;
	logic [2:0]  prefix_q, prefix_d;

	// Result list built for the byte at the input.
	entry_t      ent [MaxRes];
	logic [2:0]  n_ent;

	// Result buffer: holds the list of the last accepted byte, drained one beat a cycle while m_tready is high.
	entry_t      batch_q [MaxRes];
	logic [2:0]  cnt_q;
	logic [2:0]  idx_q;
	logic [31:0] crc_q;

	entry_t      cur;
	logic        in_acc, out_acc, out_last;

	assign cur      = batch_q[idx_q];
	assign m_tvalid = (cnt_q != 3'd0);
	assign out_last = (idx_q == 3'(cnt_q - 3'd1));
	assign m_tlast  = out_last;
	assign m_tuser  = cur.kind;
	assign m_tdata  = {(cur.kind == KIND_END) ? ~crc_q : 32'd0, cur.data};
	assign out_acc  = m_tvalid & m_tready;

	// Take a new byte once the buffer is empty or its final beat leaves now.
	assign s_tready = !m_tvalid || (m_tready && out_last);
	assign in_acc   = s_tvalid & s_tready;

	// Decode one byte: next state plus up to five results.
	always_comb begin
		logic [7:0] x;
		logic [2:0] k;
		logic       do_body;
		x        = s_tdata;
		k        = 3'd1;
		do_body  = 1'b0;
		mode_d   = mode_q;
		prefix_d = prefix_q;
		n_ent    = 3'd0;
		for (int i = 0; i < MaxRes; i++) begin
			ent[i] = '{kind: KIND_DATA, data: 8'd0};
		end
		case (mode_q)
			MODE_DOT: begin
				if (x == CH_DOT) begin
					ent[n_ent] = '{kind: KIND_DATA, data: CH_DOT - DATA_OFS};
					n_ent = n_ent + 3'd1;
					mode_d = MODE_BODY;
				end else if (x == CH_LF) begin
					ent[n_ent] = '{kind: KIND_END, data: 8'd0};
					n_ent = n_ent + 3'd1;
					mode_d = MODE_LSTART;
					prefix_d = 3'd0;
				end else if (x == CH_CR) begin
					mode_d = MODE_DOTCR;
				end else begin
					// lone dot is data; the byte after it is an in-line byte
					ent[n_ent] = '{kind: KIND_DATA, data: CH_DOT - DATA_OFS};
					n_ent = n_ent + 3'd1;
					do_body = 1'b1;
				end
			end
			MODE_DOTCR: begin
				if (x == CH_LF) begin
					ent[n_ent] = '{kind: KIND_END, data: 8'd0};
					n_ent = n_ent + 3'd1;
					mode_d = MODE_LSTART;
					prefix_d = 3'd0;
				end else begin
					ent[n_ent] = '{kind: KIND_DATA, data: CH_DOT - DATA_OFS};
					n_ent = n_ent + 3'd1;
					do_body = 1'b1;
				end
			end
			MODE_PREFIX: begin
				k = prefix_q;
				if (k < 3'd1 || k > 3'd5) begin
					k = 3'd1;
				end
				if (x == yend_char(k)) begin
					if (k == 3'd5) begin
						mode_d = MODE_SKIP;
						prefix_d = 3'd0;
					end else begin
						prefix_d = k + 3'd1;
					end
				end else begin
					prefix_d = 3'd0;
					if (k == 3'd1) begin
						ent[n_ent] = '{kind: KIND_DATA, data: x - ESC_OFS};
						n_ent = n_ent + 3'd1;
						mode_d = MODE_BODY;
					end else begin
						// replay the matched part of the tag, then the failing byte
						ent[n_ent] = '{kind: KIND_DATA, data: CH_Y - ESC_OFS};
						n_ent = n_ent + 3'd1;
						for (int i = 2; i < MaxRes; i++) begin
							if (3'(i) < k) begin
								ent[n_ent] = '{kind: KIND_DATA,
									data: yend_char(3'(i)) - DATA_OFS};
								n_ent = n_ent + 3'd1;
							end
						end
						do_body = 1'b1;
					end
				end
			end
			MODE_BODY: begin
				do_body = 1'b1;
			end
			MODE_ESC: begin
				ent[n_ent] = '{kind: KIND_DATA, data: x - ESC_OFS};
				n_ent = n_ent + 3'd1;
				mode_d = MODE_BODY;
			end
			MODE_SKIP: begin
				if (x == CH_LF) begin
					mode_d = MODE_LSTART;
				end
			end
			default: begin
				// line start
				if (x == CH_DOT) begin
					mode_d = MODE_DOT;
				end else if (x == CH_EQ) begin
					mode_d = MODE_PREFIX;
					prefix_d = 3'd1;
				end else begin
					do_body = 1'b1;
				end
			end
		endcase
		// ordinary in-line byte
		if (do_body) begin
			mode_d = MODE_BODY;
			if (x == CH_NUL) begin
				ent[n_ent] = '{kind: KIND_ERR, data: 8'd0};
				n_ent = n_ent + 3'd1;
			end else if (x == CH_LF) begin
				mode_d = MODE_LSTART;
			end else if (x == CH_EQ) begin
				mode_d = MODE_ESC;
			end else if (x != CH_CR) begin
				ent[n_ent] = '{kind: KIND_DATA, data: x - DATA_OFS};
				n_ent = n_ent + 3'd1;
			end
		end
	end

	// Decoder state: advance only on an accepted beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_LSTART;
			prefix_q <= 3'd0;
		end else if (in_acc) begin
			mode_q   <= mode_d;
			prefix_q <= prefix_d;
		end
	end

	// Buffer control and running CRC.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
			idx_q <= 3'd0;
			crc_q <= '1;
		end else begin
			if (out_acc) begin
				if (cur.kind == KIND_DATA) begin
					crc_q <= crc_byte(crc_q, cur.data);
				end else if (cur.kind == KIND_END) begin
					crc_q <= '1;
				end
			end
			if (in_acc) begin
				cnt_q <= n_ent;
				idx_q <= 3'd0;
			end else if (out_acc) begin
				if (out_last) begin
					cnt_q <= 3'd0;
					idx_q <= 3'd0;
				end else begin
					idx_q <= idx_q + 3'd1;
				end
			end
		end
	end

	// Result payload: load the whole list on accept.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < MaxRes; i++) begin
				batch_q[i] <= ent[i];
			end
		end
	end

	`YAD_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= 3'(MaxRes), "result count beyond five")
	`YAD_ASSERT_IMP(a_idx_in_list, cnt_q != 3'd0, idx_q < cnt_q, "beat index past list end")
	`YAD_ASSERT_IMP(a_no_overwrite, m_tvalid && s_tready, m_tready && m_tlast, "list overwritten before drained")
	`YAD_ASSERT_NXT(a_crc_preset, out_acc && cur.kind == KIND_END, crc_q == 32'hFFFF_FFFF, "crc not preset after end")

endmodule
